// ===== rtl/lgs_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the life generation step unit
package lgs_pkg;

	localparam int GRID_WIDTH_DEF  = 16;
	localparam int GRID_HEIGHT_DEF = 16;

	localparam int OPCODE_W = 2;
	localparam int COL_W    = 4;
	localparam int ROW_W    = 4;
	localparam int MASK_W   = 9;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_STEP  = 2'd2;

	localparam logic REG_SURVIVAL = 1'b0;
	localparam logic REG_BIRTH    = 1'b1;

	// default rule set: survive on two or three, born on three
	localparam logic [MASK_W-1:0] SURVIVAL_RESET = 9'd12;
	localparam logic [MASK_W-1:0] BIRTH_RESET    = 9'd8;

	// neighborhood of the cell under update, edges already masked
	typedef struct packed {
		logic [7:0] nbr;
		logic       center;
	} win_t;

endpackage

// ===== rtl/lgs_if.sv =====
`timescale 1ns / 1ps
// request and response channel interfaces
interface lgs_req_if;
	logic                          valid;
	logic                          ready;
	logic [lgs_pkg::OPCODE_W-1:0]  opcode;
	logic [lgs_pkg::COL_W-1:0]     col;
	logic [lgs_pkg::ROW_W-1:0]     row;
	logic                          cell_in;

	modport source (output valid, opcode, col, row, cell_in, input ready);
	modport sink (input valid, opcode, col, row, cell_in, output ready);
endinterface

interface lgs_rsp_if;
	logic valid;
	logic ready;
	logic cell_out;
	logic op_done;

	modport source (output valid, cell_out, op_done, input ready);
	modport sink (input valid, cell_out, op_done, output ready);
endinterface

// ===== rtl/lgs_ram.sv =====
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
module lgs_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/lgs_window.sv =====
`timescale 1ns / 1ps
// two-row line buffer giving the 3x3 neighborhood of the cell under update
module lgs_window #(
	parameter int GRID_WIDTH = lgs_pkg::GRID_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          push,
	input  logic          push_bit,
	input  logic          adv,
	output lgs_pkg::win_t win
);
	import lgs_pkg::*;

	localparam int W      = GRID_WIDTH;
	localparam int SH_LEN = 2 * W + 3;
	localparam int CW     = $clog2(W);

	logic [SH_LEN-1:0] sh_q;
	logic [CW-1:0]     col_q;
	logic              at_left;
	logic              at_right;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q  <= '0;
			col_q <= '0;
		end else if (clr) begin
			sh_q  <= '0;
			col_q <= '0;
		end else begin
			if (push) begin
				sh_q <= {sh_q[SH_LEN-2:0], push_bit};
			end
			if (adv) begin
				col_q <= at_right ? '0 : col_q + 1'b1;
			end
		end
	end

	assign at_left  = (col_q == '0);
	assign at_right = (col_q == CW'(W - 1));

	// newest bit is the lower right neighbor; rows above and below the grid read as zero
	assign win.nbr[0] = sh_q[0]         & ~at_right;
	assign win.nbr[1] = sh_q[1];
	assign win.nbr[2] = sh_q[2]         & ~at_left;
	assign win.nbr[3] = sh_q[W]         & ~at_right;
	assign win.nbr[4] = sh_q[W + 2]     & ~at_left;
	assign win.nbr[5] = sh_q[2 * W]     & ~at_right;
	assign win.nbr[6] = sh_q[2 * W + 1];
	assign win.nbr[7] = sh_q[2 * W + 2] & ~at_left;
	assign win.center = sh_q[W + 1];

endmodule

// ===== rtl/lgs_rule.sv =====
`timescale 1ns / 1ps
// neighbor count and survival / birth rule for one cell
module lgs_rule (
	input  lgs_pkg::win_t                win,
	input  logic [lgs_pkg::MASK_W-1:0]   survival_mask,
	input  logic [lgs_pkg::MASK_W-1:0]   birth_mask,
	output logic                         nxt
);
	import lgs_pkg::*;

	always_comb begin
		logic [3:0] cnt;
		cnt = '0;
		for (int i = 0; i < 8; i++) begin
			cnt = cnt + 4'(win.nbr[i]);
		end
		nxt = win.center ? survival_mask[cnt] : birth_mask[cnt];
	end

endmodule

// ===== rtl/life_generation_step_unit.sv =====
`timescale 1ns / 1ps
// life generation step unit: top level with sequencer, double-buffered grid and config port
// responses: a write or unused opcode loads the response register when taken, a read after ST_RD, an
// advance at the end of ST_GEN (one cell per cycle through the shared neighbor/rule unit, plus line buffer fill)
// throughput: one request at a time; the next is taken once the response register is free
// reset: masks return to {2,3} survive / {3} born, then a clearing pass over all W*H cells
// zeroes both grid buffers before the first request is taken
module life_generation_step_unit #(
	parameter int GRID_WIDTH  = lgs_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = lgs_pkg::GRID_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lgs_pkg::PADDR_W-1:0]  paddr,
	input  logic [lgs_pkg::PDATA_W-1:0]  pwdata,
	output logic [lgs_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	lgs_req_if.sink                      req,
	lgs_rsp_if.source                    rsp
);
	import lgs_pkg::*;

	localparam int N     = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(N);
	localparam int LAST  = N + GRID_WIDTH + 2;
	localparam int CNT_W = $clog2(LAST + 1);
	// first cycle of an advance at which the window holds a complete neighborhood
	localparam int WR_START = GRID_WIDTH + 3;

	typedef enum logic [3:0] {
		ST_CLR  = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_RD   = 4'b0100,
		ST_GEN  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              sel_q;       // which buffer holds the visible grid
	logic              rvalid_q;    // read data this cycle belongs to the grid
	logic              rd_in_q;     // read request addressed a cell inside the grid
	logic              out_valid_q;
	logic              cell_out_q;
	logic [MASK_W-1:0] survival_q;
	logic [MASK_W-1:0] birth_q;

	logic          req_fire;
	logic          in_grid;
	logic [AW-1:0] req_addr;
	logic          cfg_wr;
	logic          gen_we;
	logic [AW-1:0] gen_waddr;
	logic          rule_bit;
	logic          rsp_load;
	win_t          win;

	// current / next buffer ports before steering to the two rams
	logic          cur_we;
	logic [AW-1:0] cur_waddr;
	logic          cur_wdata;
	logic          nxt_we;
	logic [AW-1:0] nxt_waddr;
	logic          nxt_wdata;
	logic [AW-1:0] raddr;
	logic          cur_rdata;
	logic          ram0_we;
	logic          ram1_we;
	logic [AW-1:0] ram0_waddr;
	logic [AW-1:0] ram1_waddr;
	logic          ram0_wdata;
	logic          ram1_wdata;
	logic          ram0_rdata;
	logic          ram1_rdata;

	// config port: always ready, register picked by word address
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_BIRTH) ? PDATA_W'(birth_q) : PDATA_W'(survival_q);

	// request decode
	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign req_fire  = req.valid && req.ready;
	assign in_grid   = (32'(req.col) < 32'(GRID_WIDTH)) && (32'(req.row) < 32'(GRID_HEIGHT));
	assign req_addr  = AW'(32'(req.row) * 32'(GRID_WIDTH) + 32'(req.col));

	// response register
	assign rsp.valid    = out_valid_q;
	assign rsp.cell_out = cell_out_q;
	assign rsp.op_done  = 1'b1;

	// a response is loaded when a read finishes, an advance ends, or a write / unused
	// opcode is taken; the register is always empty or draining at that edge
	assign rsp_load = (state_q == ST_RD) ||
	                  ((state_q == ST_GEN) && (cnt_q == CNT_W'(LAST))) ||
	                  (req_fire && (req.opcode != OP_READ) && (req.opcode != OP_STEP));

	// advance sweep: read cell k of the visible grid, write cell k - (W + 3) of the other
	assign gen_we    = (state_q == ST_GEN) && (cnt_q >= CNT_W'(WR_START));
	assign gen_waddr = AW'(cnt_q - CNT_W'(WR_START));

	always_comb begin
		cur_we    = 1'b0;
		cur_waddr = req_addr;
		cur_wdata = req.cell_in;
		nxt_we    = gen_we;
		nxt_waddr = gen_waddr;
		nxt_wdata = rule_bit;
		if (state_q == ST_CLR) begin
			// clearing pass writes zeros into both buffers
			cur_we    = 1'b1;
			cur_waddr = cnt_q[AW-1:0];
			cur_wdata = 1'b0;
			nxt_we    = 1'b1;
			nxt_waddr = cnt_q[AW-1:0];
			nxt_wdata = 1'b0;
		end else if (req_fire && req.opcode == OP_WRITE && in_grid) begin
			cur_we = 1'b1;
		end
	end

	assign raddr = (state_q == ST_GEN) ? cnt_q[AW-1:0] : req_addr;

	assign ram0_we    = sel_q ? nxt_we : cur_we;
	assign ram0_waddr = sel_q ? nxt_waddr : cur_waddr;
	assign ram0_wdata = sel_q ? nxt_wdata : cur_wdata;
	assign ram1_we    = sel_q ? cur_we : nxt_we;
	assign ram1_waddr = sel_q ? cur_waddr : nxt_waddr;
	assign ram1_wdata = sel_q ? cur_wdata : nxt_wdata;
	assign cur_rdata  = sel_q ? ram1_rdata : ram0_rdata;

	lgs_ram #(
		.WIDTH (1),
		.DEPTH (N)
	) u_grid0 (
		.clk   (clk),
		.we    (ram0_we),
		.waddr (ram0_waddr),
		.wdata (ram0_wdata),
		.raddr (raddr),
		.rdata (ram0_rdata)
	);

	lgs_ram #(
		.WIDTH (1),
		.DEPTH (N)
	) u_grid1 (
		.clk   (clk),
		.we    (ram1_we),
		.waddr (ram1_waddr),
		.wdata (ram1_wdata),
		.raddr (raddr),
		.rdata (ram1_rdata)
	);

	// line buffer: shifts one cell per cycle once the first read data is back
	lgs_window #(
		.GRID_WIDTH (GRID_WIDTH)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (req_fire && req.opcode == OP_STEP),
		.push     ((state_q == ST_GEN) && (cnt_q != '0)),
		.push_bit (rvalid_q & cur_rdata),
		.adv      (gen_we),
		.win      (win)
	);

	lgs_rule u_rule (
		.win           (win),
		.survival_mask (survival_q),
		.birth_mask    (birth_q),
		.nxt           (rule_bit)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			cnt_q       <= '0;
			sel_q       <= 1'b0;
			rvalid_q    <= 1'b0;
			rd_in_q     <= 1'b0;
			out_valid_q <= 1'b0;
			cell_out_q  <= 1'b0;
			survival_q  <= SURVIVAL_RESET;
			birth_q     <= BIRTH_RESET;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_BIRTH) begin
					birth_q <= pwdata[MASK_W-1:0];
				end else begin
					survival_q <= pwdata[MASK_W-1:0];
				end
			end

			if (rsp_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			rvalid_q <= (state_q == ST_GEN) && (cnt_q < CNT_W'(N));

			unique case (state_q)
				ST_CLR: begin
					if (cnt_q == CNT_W'(N - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						priority if (req.opcode == OP_READ) begin
							rd_in_q <= in_grid;
							state_q <= ST_RD;
						end else if (req.opcode == OP_STEP) begin
							cnt_q   <= '0;
							state_q <= ST_GEN;
						end else begin
							// write or unused opcode: done in this cycle
							cell_out_q <= 1'b0;
						end
					end
				end
				ST_RD: begin
					cell_out_q <= rd_in_q & cur_rdata;
					state_q    <= ST_IDLE;
				end
				ST_GEN: begin
					if (cnt_q == CNT_W'(LAST)) begin
						// last cell written: the new generation becomes visible
						cnt_q      <= '0;
						sel_q      <= ~sel_q;
						cell_out_q <= 1'b0;
						state_q    <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
